/* rtl/assert_macros.svh */
// Assertion macros used by the quaternion arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QAU_ASSERT(lbl, prop, msg)
`define QAU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/qau_pkg.sv */
// Types and constants of the quaternion arithmetic unit.
package qau_pkg;

  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MUL   = 3'd0,
    FUNC_CONJ  = 3'd1,
    FUNC_SCALE = 3'd2,
    FUNC_LEN   = 3'd3,
    FUNC_NORM  = 3'd4
  } func_e;

  // Hamilton product terms: result component c, term t uses a[MUL_L] * b[MUL_R].
  // Component order is x, y, z, w.
  localparam logic [1:0] MUL_L [4][4] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd1, 2'd2, 2'd0},
    '{2'd3, 2'd2, 2'd0, 2'd1},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam logic [1:0] MUL_R [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  // bit t set: term t is subtracted
  localparam logic [3:0] MUL_NEG [4] = '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

endpackage

/* rtl/qau_in_if.sv */
// Input channel: operation code, quaternions A and B, scalar.
interface qau_in_if #(parameter int DATA_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic [qau_pkg::FUNC_W-1:0]     func;
  logic signed [DATA_WIDTH-1:0]   a_x;
  logic signed [DATA_WIDTH-1:0]   a_y;
  logic signed [DATA_WIDTH-1:0]   a_z;
  logic signed [DATA_WIDTH-1:0]   a_w;
  logic signed [DATA_WIDTH-1:0]   b_x;
  logic signed [DATA_WIDTH-1:0]   b_y;
  logic signed [DATA_WIDTH-1:0]   b_z;
  logic signed [DATA_WIDTH-1:0]   b_w;
  logic signed [DATA_WIDTH-1:0]   scale;

  modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale,
                output ready);
endinterface

/* rtl/qau_out_if.sv */
// Output channel: result quaternion, length and zero-length flag.
interface qau_out_if #(parameter int DATA_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [DATA_WIDTH-1:0]   r_x;
  logic signed [DATA_WIDTH-1:0]   r_y;
  logic signed [DATA_WIDTH-1:0]   r_z;
  logic signed [DATA_WIDTH-1:0]   r_w;
  logic [DATA_WIDTH-1:0]          magnitude;
  logic                           zero_length;

  modport source (output valid, r_x, r_y, r_z, r_w, magnitude, zero_length, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, magnitude, zero_length, output ready);
endinterface

/* rtl/quaternion_arithmetic_unit.sv */
// Quaternion ALU top level: pipelined Q format multiply, conjugate, scale, length, normalize.
// Stage order: input, products, sums, round, root, root round, dividends, divide, output.
// Throughput: one transaction per cycle; the whole pipe holds while the output stalls.
// Length takes one root bit per stage, normalize one quotient bit per stage.
// Reset clears all stage valid bits; data registers are not reset.
`include "assert_macros.svh"
module quaternion_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qau_in_if.sink   in_i,
  qau_out_if.source out_o
);

  localparam int N   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * N;
  localparam int SW  = 2 * N + 2;
  localparam int TW  = 2 * N + 1;
  localparam int NW  = N + F + 2;
  localparam int QW  = F + 1;
  localparam int NST = N + F + 8;
  localparam int FW  = qau_pkg::FUNC_W;

  typedef struct packed {
    logic [FW-1:0]       func;
    logic [3:0][N-1:0]   res;
    logic [3:0][N-1:0]   amag;
    logic [3:0]          aneg;
    logic                sat;
  } ctx_t;

  function automatic logic [N-1:0] fit_w(input logic signed [SW-1:0] v);
    logic ovf;
    ovf = !((&v[SW-1:N-1]) || (~|v[SW-1:N-1]));
    if (ovf) begin
      fit_w = v[SW-1] ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}};
    end else begin
      fit_w = v[N-1:0];
    end
  endfunction

  logic           en;
  logic [NST-1:0] vld_q;

  assign en         = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  // input register
  logic [FW-1:0]     s0_func_q;
  logic [3:0][N-1:0] s0_a_q, s0_b_q;
  logic [N-1:0]      s0_k_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_func_q <= in_i.func;
      s0_a_q    <= {in_i.a_w, in_i.a_z, in_i.a_y, in_i.a_x};
      s0_b_q    <= {in_i.b_w, in_i.b_z, in_i.b_y, in_i.b_x};
      s0_k_q    <= in_i.scale;
    end
  end

  // products: 16 multipliers shared by multiply, scale and sum of squares
  logic [3:0][3:0][PW-1:0] s1_prod_d, s1_prod_q;
  logic [3:0][3:0]         s1_neg_d, s1_neg_q;
  logic [FW-1:0]           s1_func_q;
  logic [3:0][N-1:0]       s1_a_q;

  always_comb begin
    logic signed [N-1:0] lhs;
    logic signed [N-1:0] rhs;
    logic signed [PW-1:0] p;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        lhs = '0;
        rhs = '0;
        s1_neg_d[c][t] = 1'b0;
        case (s0_func_q)
          qau_pkg::FUNC_MUL: begin
            lhs = s0_a_q[qau_pkg::MUL_L[c][t]];
            rhs = s0_b_q[qau_pkg::MUL_R[c][t]];
            s1_neg_d[c][t] = qau_pkg::MUL_NEG[c][t];
          end
          qau_pkg::FUNC_SCALE: begin
            if (t == 0) begin
              lhs = s0_a_q[2'(c)];
              rhs = s0_k_q;
            end
          end
          qau_pkg::FUNC_LEN, qau_pkg::FUNC_NORM: begin
            if (c == 0) begin
              lhs = s0_a_q[2'(t)];
              rhs = s0_a_q[2'(t)];
            end
          end
          default: begin
          end
        endcase
        p = lhs * rhs;
        s1_prod_d[c][t] = p;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= s1_prod_d;
      s1_neg_q  <= s1_neg_d;
      s1_func_q <= s0_func_q;
      s1_a_q    <= s0_a_q;
    end
  end

  // exact sums of four signed products
  logic [3:0][SW-1:0] s2_sum_d, s2_sum_q;
  logic [FW-1:0]      s2_func_q;
  logic [3:0][N-1:0]  s2_a_q;

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] term;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        term = {{2{s1_prod_q[c][t][PW-1]}}, s1_prod_q[c][t]};
        acc  = s1_neg_q[c][t] ? acc - term : acc + term;
      end
      s2_sum_d[c] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sum_q  <= s2_sum_d;
      s2_func_q <= s1_func_q;
      s2_a_q    <= s1_a_q;
    end
  end

  // round and saturate, conjugate, prepare root operand
  ctx_t          s3_ctx_d, s3_ctx_q;
  logic [PW-1:0] s3_s_q;

  always_comb begin
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] rnd;
    logic [N-1:0]         av;
    s3_ctx_d.func = s2_func_q;
    s3_ctx_d.sat  = |s2_sum_q[0][SW-1:PW];
    for (int c = 0; c < 4; c++) begin
      t   = $signed(s2_sum_q[c]) + $signed(SW'(1) << (F - 1));
      rnd = t >>> F;
      av  = s2_a_q[c];
      s3_ctx_d.aneg[c] = av[N-1];
      s3_ctx_d.amag[c] = av[N-1] ? N'(-av) : av;
      case (s2_func_q)
        qau_pkg::FUNC_MUL, qau_pkg::FUNC_SCALE: s3_ctx_d.res[c] = fit_w(rnd);
        qau_pkg::FUNC_CONJ: begin
          if (c == 3) begin
            s3_ctx_d.res[c] = av;
          end else if (av == {1'b1, {(N-1){1'b0}}}) begin
            s3_ctx_d.res[c] = {1'b0, {(N-1){1'b1}}};
          end else begin
            s3_ctx_d.res[c] = N'(-av);
          end
        end
        default: s3_ctx_d.res[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ctx_q <= s3_ctx_d;
      s3_s_q   <= s2_sum_q[0][PW-1:0];
    end
  end

  // square root, one result bit per stage, most significant first
  logic [PW-1:0] sq_rem_in [N];
  logic [N-1:0]  sq_root_in [N];
  ctx_t          sq_ctx_in [N];
  logic [PW-1:0] sq_rem_d [N], sq_rem_q [N];
  logic [N-1:0]  sq_root_d [N], sq_root_q [N];
  ctx_t          sq_ctx_q [N];

  always_comb begin
    sq_rem_in[0]  = s3_s_q;
    sq_root_in[0] = '0;
    sq_ctx_in[0]  = s3_ctx_q;
    for (int k = 1; k < N; k++) begin
      sq_rem_in[k]  = sq_rem_q[k-1];
      sq_root_in[k] = sq_root_q[k-1];
      sq_ctx_in[k]  = sq_ctx_q[k-1];
    end
  end

  always_comb begin
    logic [TW-1:0] trial;
    int            i;
    for (int k = 0; k < N; k++) begin
      i     = N - 1 - k;
      trial = (TW'(sq_root_in[k]) << (i + 1)) | (TW'(1) << (2 * i));
      sq_rem_d[k]  = sq_rem_in[k];
      sq_root_d[k] = sq_root_in[k];
      if ({1'b0, sq_rem_in[k]} >= trial) begin
        sq_rem_d[k]  = sq_rem_in[k] - trial[PW-1:0];
        sq_root_d[k] = sq_root_in[k] | (N'(1) << i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
        sq_ctx_q[k]  <= sq_ctx_in[k];
      end
    end
  end

  // round the root to nearest, saturate
  logic [N-1:0] s4_mag_d, s4_mag_q;
  ctx_t         s4_ctx_q;

  always_comb begin
    logic [N-1:0] r;
    logic         up;
    r  = sq_root_q[N-1];
    up = sq_rem_q[N-1] > {{N{1'b0}}, r};
    if (sq_ctx_q[N-1].sat) begin
      s4_mag_d = '1;
    end else if (up && (r != '1)) begin
      s4_mag_d = r + N'(1);
    end else begin
      s4_mag_d = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mag_q <= s4_mag_d;
      s4_ctx_q <= sq_ctx_q[N-1];
    end
  end

  // dividends for normalize: 2*|a|*2^F + m, divisor 2*m
  logic [3:0][NW-1:0] s5_rem_d, s5_rem_q;
  logic [N-1:0]       s5_mag_q;
  ctx_t               s5_ctx_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s5_rem_d[c] = (NW'(s4_ctx_q.amag[c]) << (F + 1)) + NW'(s4_mag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_rem_q <= s5_rem_d;
      s5_mag_q <= s4_mag_q;
      s5_ctx_q <= s4_ctx_q;
    end
  end

  // restoring division, four lanes, one quotient bit per stage
  logic [3:0][NW-1:0] dv_rem_in [QW];
  logic [3:0][QW-1:0] dv_quo_in [QW];
  logic [N-1:0]       dv_mag_in [QW];
  ctx_t               dv_ctx_in [QW];
  logic [3:0][NW-1:0] dv_rem_d [QW], dv_rem_q [QW];
  logic [3:0][QW-1:0] dv_quo_d [QW], dv_quo_q [QW];
  logic [N-1:0]       dv_mag_q [QW];
  ctx_t               dv_ctx_q [QW];

  always_comb begin
    dv_rem_in[0] = s5_rem_q;
    dv_quo_in[0] = '0;
    dv_mag_in[0] = s5_mag_q;
    dv_ctx_in[0] = s5_ctx_q;
    for (int k = 1; k < QW; k++) begin
      dv_rem_in[k] = dv_rem_q[k-1];
      dv_quo_in[k] = dv_quo_q[k-1];
      dv_mag_in[k] = dv_mag_q[k-1];
      dv_ctx_in[k] = dv_ctx_q[k-1];
    end
  end

  always_comb begin
    logic [NW-1:0] trial;
    int            i;
    for (int k = 0; k < QW; k++) begin
      i     = F - k;
      trial = NW'(dv_mag_in[k]) << (i + 1);
      for (int c = 0; c < 4; c++) begin
        dv_rem_d[k][c] = dv_rem_in[k][c];
        dv_quo_d[k][c] = dv_quo_in[k][c];
        if (dv_rem_in[k][c] >= trial) begin
          dv_rem_d[k][c] = dv_rem_in[k][c] - trial;
          dv_quo_d[k][c] = dv_quo_in[k][c] | (QW'(1) << i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        dv_rem_q[k] <= dv_rem_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
        dv_mag_q[k] <= dv_mag_in[k];
        dv_ctx_q[k] <= dv_ctx_in[k];
      end
    end
  end

  // result select and output register
  logic [3:0][N-1:0] out_r_d, out_r_q;
  logic [N-1:0]      out_mag_d, out_mag_q;
  logic              out_zl_d, out_zl_q;

  always_comb begin
    logic signed [SW-1:0] sv;
    ctx_t                 cx;
    logic [N-1:0]         m;
    cx        = dv_ctx_q[QW-1];
    m         = dv_mag_q[QW-1];
    out_r_d   = cx.res;
    out_mag_d = '0;
    out_zl_d  = 1'b0;
    case (cx.func)
      qau_pkg::FUNC_LEN: out_mag_d = m;
      qau_pkg::FUNC_NORM: begin
        out_mag_d = m;
        if (m == '0) begin
          out_zl_d = 1'b1;
          out_r_d  = '0;
        end else begin
          for (int c = 0; c < 4; c++) begin
            sv = SW'({1'b0, dv_quo_q[QW-1][c]});
            if (cx.aneg[c]) begin
              sv = -sv;
            end
            out_r_d[c] = fit_w(sv);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_r_q   <= out_r_d;
      out_mag_q <= out_mag_d;
      out_zl_q  <= out_zl_d;
    end
  end

  assign out_o.valid       = vld_q[NST-1];
  assign out_o.r_x         = out_r_q[0];
  assign out_o.r_y         = out_r_q[1];
  assign out_o.r_z         = out_r_q[2];
  assign out_o.r_w         = out_r_q[3];
  assign out_o.magnitude   = out_mag_q;
  assign out_o.zero_length = out_zl_q;

  `QAU_ASSERT(a_zl_clean, out_o.valid && out_o.zero_length |-> out_o.magnitude == '0 && out_o.r_x == '0 && out_o.r_y == '0 && out_o.r_z == '0 && out_o.r_w == '0, "zero length result not cleared")
  `QAU_ASSERT(a_stall_ready, out_o.valid && !out_o.ready |-> !in_i.ready, "input taken during output stall")
  `QAU_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "pipe valid bits moved during stall")
  `QAU_ASSERT_RST(a_rst_idle, !rst_ni |=> vld_q == '0, "valid bits set during reset")

endmodule
